// ===== hw/rtl/curve_point_and_tangent_evaluator_assert.svh =====
// assertion macros shared by the curve evaluator rtl
// expects clk and rst_n in the scope of each use
`ifndef CURVE_POINT_AND_TANGENT_EVALUATOR_ASSERT_SVH
`define CURVE_POINT_AND_TANGENT_EVALUATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define CPTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CPTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cpte_pkg.sv =====
// types, codes and constants of the curve point and tangent evaluator
// no dependencies
`default_nettype none

package cpte_pkg;

  localparam int CORDIC_STEPS     = 30;
  localparam int CORDIC_PER_STAGE = 3;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CW               = 32;

  localparam logic [29:0] IV2PI_Q32 = 30'd683565276;
  localparam logic [32:0] TWOPI_Q30 = 33'd6746518852;
  localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

  typedef enum logic [1:0] {
    KIND_CIRCLE  = 2'd0,
    KIND_ELLIPSE = 2'd1,
    KIND_HELIX   = 2'd2
  } cpte_kind_t;

  typedef enum logic [1:0] {
    REG_KIND     = 2'd0,
    REG_RADIUS_A = 2'd1,
    REG_RADIUS_B = 2'd2,
    REG_PITCH    = 2'd3
  } cpte_reg_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] quad;
  } cpte_tag_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 32'sd843314857;
      1:  v = 32'sd497837829;
      2:  v = 32'sd263043837;
      3:  v = 32'sd133525159;
      4:  v = 32'sd67021687;
      5:  v = 32'sd33543516;
      6:  v = 32'sd16775851;
      7:  v = 32'sd8388437;
      8:  v = 32'sd4194283;
      9:  v = 32'sd2097149;
      10: v = 32'sd1048576;
      11: v = 32'sd524288;
      12: v = 32'sd262144;
      13: v = 32'sd131072;
      14: v = 32'sd65536;
      15: v = 32'sd32768;
      16: v = 32'sd16384;
      17: v = 32'sd8192;
      18: v = 32'sd4096;
      19: v = 32'sd2048;
      20: v = 32'sd1024;
      21: v = 32'sd512;
      22: v = 32'sd256;
      23: v = 32'sd128;
      24: v = 32'sd64;
      25: v = 32'sd32;
      26: v = 32'sd16;
      27: v = 32'sd8;
      28: v = 32'sd4;
      29: v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/curve_point_and_tangent_evaluator.sv =====
// curve point and tangent evaluator: circle, ellipse or helix from an angle
// depends on cpte_pkg, cpte_cordic and curve_point_and_tangent_evaluator_assert.svh
//
// channel   ports                                   handshake
// config    cfg_we cfg_index cfg_wdata              write when cfg_we high
// input     start busy in_angle                     taken when start and not busy
// result    out_strobe out_pos_* out_tan_*          one cycle, cannot be held off
//
// one item per cycle while busy is low; the strobe rises once the accepted item has passed
// angle scale, phase, the 10-stage cordic, multiply and round
// busy is high during reset and the cycle after it, low from then on
// synchronous active-low reset clears valid bits and sets config registers to defaults
`default_nettype none

`include "curve_point_and_tangent_evaluator_assert.svh"

module curve_point_and_tangent_evaluator #(
  parameter int PHASE_BITS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [31:0] in_angle,
  output      logic               out_strobe,
  output      logic signed [25:0] out_pos_x,
  output      logic signed [25:0] out_pos_y,
  output      logic signed [41:0] out_pos_z,
  output      logic signed [25:0] out_tan_x,
  output      logic signed [25:0] out_tan_y,
  output      logic [24:0]        out_tan_z
);

  localparam int ZS_W    = PHASE_BITS + 32;
  localparam int HLINE   = cpte_pkg::CORDIC_STAGES + 1;
  localparam int LATENCY = cpte_pkg::CORDIC_STAGES + 4;
  localparam int CW      = cpte_pkg::CW;

  // config registers
  logic        busy_r;
  logic [1:0]  cfg_kind_r;
  logic [23:0] cfg_a_r, cfg_b_r, cfg_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      cfg_kind_r  <= cpte_pkg::KIND_CIRCLE;
      cfg_a_r     <= 24'd65536;
      cfg_b_r     <= 24'd65536;
      cfg_pitch_r <= 24'd65536;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cpte_pkg::cpte_reg_t'(cfg_index))
          cpte_pkg::REG_KIND:     cfg_kind_r  <= cfg_wdata[1:0];
          cpte_pkg::REG_RADIUS_A: cfg_a_r     <= cfg_wdata;
          cpte_pkg::REG_RADIUS_B: cfg_b_r     <= cfg_wdata;
          cpte_pkg::REG_PITCH:    cfg_pitch_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // stage 1: turns = angle / 2pi
  logic               v1_r;
  logic signed [61:0] prod_r;
  logic signed [61:0] prod_nxt;

  assign prod_nxt = in_angle * $signed({1'b0, cpte_pkg::IV2PI_Q32});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // stage 2: phase to radians, helix products
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-3:0] rem;
  logic [ZS_W-1:0]       zsum;
  logic signed [18:0]    turns_hi;
  logic [18:0]           turns_lo;
  logic [54:0]           tzsum;

  cpte_pkg::cpte_tag_t tag2_r;
  logic signed [CW-1:0] z0_r;
  logic [42:0]          plo_r;
  logic signed [43:0]   phi_r;
  logic [21:0]          tz_r;

  assign phase    = prod_r[52-PHASE_BITS +: PHASE_BITS];
  assign rem      = phase[PHASE_BITS-3:0];
  assign zsum     = ZS_W'(rem) * ZS_W'(cpte_pkg::TWOPI_Q30) + (ZS_W'(1) << (PHASE_BITS - 1));
  assign turns_hi = prod_r[61:43];
  assign turns_lo = prod_r[42:24];
  assign tzsum    = 55'(cfg_pitch_r) * 55'(cpte_pkg::IV2PI_Q32) + (55'(1) << 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r.vld  <= v1_r;
      tag2_r.quad <= phase[PHASE_BITS-1 -: 2];
    end
  end

  always_ff @(posedge clk) begin
    z0_r  <= $signed(zsum[PHASE_BITS +: CW]);
    plo_r <= cfg_pitch_r * turns_lo;
    phi_r <= $signed({1'b0, cfg_pitch_r}) * turns_hi;
    tz_r  <= tzsum[32 +: 22];
  end

  // helix terms, delayed alongside the cordic
  logic signed [69:0] pzsum;
  logic signed [41:0] pzl_r [HLINE];
  logic [21:0]        tzl_r [HLINE];

  assign pzsum = (70'(phi_r) <<< 19) + $signed(70'(plo_r)) + (70'sd1 <<< 27);

  always_ff @(posedge clk) begin
    pzl_r[0] <= pzsum[28 +: 42];
    tzl_r[0] <= tz_r;
    for (int i = 1; i < HLINE; i++) begin
      pzl_r[i] <= pzl_r[i-1];
      tzl_r[i] <= tzl_r[i-1];
    end
  end

  // cordic stages
  cpte_pkg::cpte_tag_t  ctag;
  logic signed [CW-1:0] cx, cy;

  cpte_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (tag2_r),
    .in_z    (z0_r),
    .out_tag (ctag),
    .out_x   (cx),
    .out_y   (cy)
  );

  // quadrant fold and radius products
  logic signed [CW:0]   cval, sval;
  logic signed [24:0]   a_s, b_s;
  logic                 mvld_r;
  logic signed [57:0]   mac_r, mbs_r, mas_r, mbc_r;

  always_comb begin
    case (ctag.quad)
      2'd0: begin
        cval = (CW+1)'(cx);
        sval = (CW+1)'(cy);
      end
      2'd1: begin
        cval = -(CW+1)'(cy);
        sval = (CW+1)'(cx);
      end
      2'd2: begin
        cval = -(CW+1)'(cx);
        sval = -(CW+1)'(cy);
      end
      default: begin
        cval = (CW+1)'(cy);
        sval = -(CW+1)'(cx);
      end
    endcase
    a_s = $signed({1'b0, cfg_a_r});
    b_s = (cfg_kind_r == cpte_pkg::KIND_ELLIPSE) ? $signed({1'b0, cfg_b_r}) : a_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else begin
      mvld_r <= ctag.vld;
    end
  end

  always_ff @(posedge clk) begin
    mac_r <= a_s * cval;
    mbs_r <= b_s * sval;
    mas_r <= a_s * sval;
    mbc_r <= b_s * cval;
  end

  // rounding and output registers
  logic signed [57:0] sac, sbs, sas, sbc;
  logic               helix;
  logic               out_strobe_r;
  logic signed [25:0] out_pos_x_r, out_pos_y_r, out_tan_x_r, out_tan_y_r;
  logic signed [41:0] out_pos_z_r;
  logic [24:0]        out_tan_z_r;

  assign sac   = mac_r + (58'sd1 <<< 29);
  assign sbs   = mbs_r + (58'sd1 <<< 29);
  assign sas   = mas_r + (58'sd1 <<< 29);
  assign sbc   = mbc_r + (58'sd1 <<< 29);
  assign helix = (cfg_kind_r == cpte_pkg::KIND_HELIX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_x_r <= sac[30 +: 26];
    out_pos_y_r <= sbs[30 +: 26];
    out_tan_x_r <= -sas[30 +: 26];
    out_tan_y_r <= sbc[30 +: 26];
    out_pos_z_r <= helix ? pzl_r[HLINE-1] : '0;
    out_tan_z_r <= helix ? 25'(tzl_r[HLINE-1]) : '0;
  end

  assign out_strobe = out_strobe_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;
  assign out_pos_z  = out_pos_z_r;
  assign out_tan_x  = out_tan_x_r;
  assign out_tan_y  = out_tan_y_r;
  assign out_tan_z  = out_tan_z_r;

  `CPTE_ASSERT_IMP(a_result_latency, out_strobe_r, $past(start && !busy_r, LATENCY), "result without accepted item")
  `CPTE_ASSERT_IMP(a_flat_z, out_strobe_r && $past(cfg_kind_r != cpte_pkg::KIND_HELIX), out_pos_z_r == '0 && out_tan_z_r == '0, "z terms set off helix")
  `CPTE_ASSERT_IMP(a_round_sym, out_strobe_r && $past(cfg_kind_r != cpte_pkg::KIND_ELLIPSE, 2), out_pos_x_r == out_tan_y_r && out_tan_x_r == -out_pos_y_r, "equal axes give unequal terms")
  `CPTE_ASSERT_NXT(a_busy_stays_low, !busy_r, !busy_r, "busy rose outside reset")

endmodule

`default_nettype wire

// ===== hw/rtl/cpte_cordic.sv =====
// pipelined rotation-mode cordic, a few iterations per register stage
// depends on cpte_pkg and curve_point_and_tangent_evaluator_assert.svh
`default_nettype none

`include "curve_point_and_tangent_evaluator_assert.svh"

module cpte_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cpte_pkg::cpte_tag_t           in_tag,
  input  wire logic signed [cpte_pkg::CW-1:0] in_z,
  output      cpte_pkg::cpte_tag_t           out_tag,
  output      logic signed [cpte_pkg::CW-1:0] out_x,
  output      logic signed [cpte_pkg::CW-1:0] out_y
);

  localparam int NST  = cpte_pkg::CORDIC_STAGES;
  localparam int PER  = cpte_pkg::CORDIC_PER_STAGE;
  localparam int LAST = NST - 1;

  cpte_pkg::cpte_tag_t           tag_r [NST];
  logic signed [cpte_pkg::CW-1:0] x_r  [NST];
  logic signed [cpte_pkg::CW-1:0] y_r  [NST];
  logic signed [cpte_pkg::CW-1:0] z_r  [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    cpte_pkg::cpte_tag_t           ti;
    logic signed [cpte_pkg::CW-1:0] xi, yi, zi;
    logic signed [cpte_pkg::CW-1:0] xo, yo, zo;

    if (g == 0) begin : g_first
      assign ti = in_tag;
      assign xi = cpte_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = in_z;
    end else begin : g_next
      assign ti = tag_r[g-1];
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
    end

    always_comb begin
      logic signed [cpte_pkg::CW-1:0] dx, dy;
      xo = xi;
      yo = yi;
      zo = zi;
      for (int k = 0; k < PER; k++) begin
        dx = yo >>> (g * PER + k);
        dy = xo >>> (g * PER + k);
        if (!zo[cpte_pkg::CW-1]) begin
          xo = xo - dx;
          yo = yo + dy;
          zo = zo - cpte_pkg::atan_q30(g * PER + k);
        end else begin
          xo = xo + dx;
          yo = yo - dy;
          zo = zo + cpte_pkg::atan_q30(g * PER + k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g] <= '0;
      end else begin
        tag_r[g] <= ti;
      end
    end

    always_ff @(posedge clk) begin
      x_r[g] <= xo;
      y_r[g] <= yo;
      z_r[g] <= zo;
    end
  end

  assign out_tag = tag_r[LAST];
  assign out_x   = x_r[LAST];
  assign out_y   = y_r[LAST];

  `CPTE_ASSERT_IMP(a_cordic_latency, tag_r[LAST].vld, $past(in_tag.vld, NST), "cordic item without matching entry")
  `CPTE_ASSERT_IMP(a_cordic_quad, tag_r[LAST].vld, tag_r[LAST].quad == $past(in_tag.quad, NST), "quadrant lost in cordic")
  `CPTE_ASSERT_IMP(a_cordic_cos_sign, tag_r[LAST].vld, !x_r[LAST][cpte_pkg::CW-1], "negative cosine within first quadrant")

endmodule

`default_nettype wire
